### hw/rtl/rc4_pkg.sv
// Shared types and constants for the RC4 keystream engine.
package rc4_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned KEY_LEN_W = 5;

    // Key bytes 0..15 after reset, byte 0 in the low bits.
    localparam logic [127:0] KEY_RESET = 128'h0000000000000000_00776F5E4D3C2B1A;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    typedef enum logic [1:0] {
        REQ_INIT = 2'd0,
        REQ_STEP = 2'd1,
        REQ_READ = 2'd2,
        REQ_NOP  = 2'd3
    } req_code_t;

    typedef struct packed {
        req_code_t       req_type;
        logic [7:0]      entry_index;
    } rc4_req_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] index_i;
        logic [7:0] index_j;
    } rc4_rsp_t;

    // Sequencer to table memory.
    typedef struct packed {
        logic       clr;
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } mem_req_t;

endpackage

### hw/rtl/rc4_sbox_mem.sv
// Permutation table: 256x8 synchronous RAM with per-entry valid bits for identity reset.
module rc4_sbox_mem
    import rc4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mem_req_t   mem_req,
    output logic [7:0] rd_data
);

    logic [7:0]   mem [256];
    logic [255:0] vld_reg;
    logic [7:0]   rd_q_reg;
    logic         rd_vld_reg;
    logic [7:0]   rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd_q_reg    <= mem[mem_req.raddr];
        rd_addr_reg <= mem_req.raddr;
    end

    // Entry not written since last clear reads as its own index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[mem_req.raddr];
            if (mem_req.clr)
            begin
                vld_reg <= '0;
            end
            else if (mem_req.we)
            begin
                vld_reg[mem_req.waddr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : rd_addr_reg;

endmodule

### hw/rtl/rc4_seq.sv
// Request sequencer: key schedule, keystream step and table read over one RAM.
module rc4_seq
    import rc4_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 16,
    parameter int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  rc4_req_t                         req,
    output logic                             busy,
    output logic                             done,
    output rc4_rsp_t                         rsp,
    input  logic [MAX_KEY_BYTES-1:0][7:0]    key_bytes,
    input  logic [KW-1:0]                    key_last,
    output mem_req_t                         mem_req,
    input  logic [7:0]                       rd_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RA   = 6'b000010,
        ST_RB   = 6'b000100,
        ST_WA   = 6'b001000,
        ST_WB   = 6'b010000,
        ST_RE   = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic          ksa_reg, ksa_next;
    logic [7:0]    a_reg, a_next;
    logic [7:0]    i_reg, i_next;
    logic [7:0]    j_reg, j_next;
    logic [7:0]    sa_reg, sa_next;
    logic [7:0]    sb_reg, sb_next;
    logic [KW-1:0] kpos_reg, kpos_next;
    logic          done_reg, done_next;
    rc4_rsp_t      rsp_reg, rsp_next;

    logic          accept;
    logic [7:0]    key_add;
    logic [7:0]    t_sum;
    logic [7:0]    ks_byte;

    assign accept  = start && (state_reg == ST_IDLE);
    assign key_add = ksa_reg ? key_bytes[kpos_reg] : 8'd0;
    assign t_sum   = sa_reg + sb_reg;

    // Output entry after the swap: the two swapped slots come from registers.
    always_comb
    begin
        priority if (t_sum == j_reg)
            ks_byte = sa_reg;
        else if (t_sum == a_reg)
            ks_byte = sb_reg;
        else
            ks_byte = rd_data;
    end

    always_comb
    begin
        state_next = state_reg;
        ksa_next   = ksa_reg;
        a_next     = a_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        kpos_next  = kpos_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.raddr = i_reg + 8'd1;
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_INIT:
                        begin
                            mem_req.clr = 1'b1;
                            ksa_next    = 1'b1;
                            a_next      = 8'd0;
                            j_next      = 8'd0;
                            kpos_next   = '0;
                            state_next  = ST_RA;
                        end
                        REQ_STEP:
                        begin
                            ksa_next   = 1'b0;
                            i_next     = i_reg + 8'd1;
                            a_next     = i_reg + 8'd1;
                            state_next = ST_RB;
                        end
                        REQ_READ:
                        begin
                            mem_req.raddr = req.entry_index;
                            state_next    = ST_RE;
                        end
                        REQ_NOP:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{data_byte: 8'd0, index_i: i_reg, index_j: j_reg};
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RA:
            begin
                mem_req.raddr = a_reg;
                state_next    = ST_RB;
            end
            ST_RB:
            begin
                sa_next       = rd_data;
                j_next        = j_reg + rd_data + key_add;
                mem_req.raddr = j_reg + rd_data + key_add;
                state_next    = ST_WA;
            end
            ST_WA:
            begin
                sb_next       = rd_data;
                mem_req.we    = 1'b1;
                mem_req.waddr = a_reg;
                mem_req.wdata = rd_data;
                mem_req.raddr = sa_reg + rd_data;
                state_next    = ST_WB;
            end
            ST_WB:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = j_reg;
                mem_req.wdata = sa_reg;
                if (!ksa_reg)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{data_byte: ks_byte, index_i: i_reg, index_j: j_reg};
                    state_next = ST_IDLE;
                end
                else if (a_reg == 8'hFF)
                begin
                    i_next     = 8'd0;
                    j_next     = 8'd0;
                    ksa_next   = 1'b0;
                    done_next  = 1'b1;
                    rsp_next   = '{data_byte: 8'd0, index_i: 8'd0, index_j: 8'd0};
                    state_next = ST_IDLE;
                end
                else
                begin
                    a_next     = a_reg + 8'd1;
                    kpos_next  = (kpos_reg == key_last) ? '0 : kpos_reg + 1'b1;
                    state_next = ST_RA;
                end
            end
            ST_RE:
            begin
                done_next  = 1'b1;
                rsp_next   = '{data_byte: rd_data, index_i: i_reg, index_j: j_reg};
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ksa_reg   <= 1'b0;
            i_reg     <= 8'd0;
            j_reg     <= 8'd0;
            kpos_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ksa_reg   <= ksa_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            kpos_reg  <= kpos_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    a_wr_only_in_swap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (state_reg == ST_WA || state_reg == ST_WB))
        else $error("table write outside swap states");

    a_clr_only_on_init: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.clr |-> (accept && req.req_type == REQ_INIT && !mem_req.we))
        else $error("table clear without init request");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |-> (state_reg == ST_WB || state_reg == ST_RE || accept))
        else $error("result strobe from unexpected state");

    a_init_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB && ksa_reg && a_reg == 8'hFF) |=>
            (i_reg == 8'd0 && j_reg == 8'd0 && done_reg))
        else $error("key schedule did not end with cleared indices");
`endif

endmodule

### hw/rtl/rc4_keystream_engine_top.sv
// RC4 keystream engine top level: key registers, sequencer and permutation table.
//
// Usage:
//   Command channel: a word on req is taken at a rising edge with start high and
//   busy low. req_type selects init (key schedule), step (one keystream byte),
//   read (table entry at entry_index) or no-op.
//   Result channel: every command yields exactly one word on rsp, marked by done
//   for a single cycle. The receiver cannot stall; it must take the word then.
//   Sequence of each command, from the accepting edge to the done cycle:
//     step : the next command is accepted in the done cycle. The steps are set
//            by the RAM's single read port: read S[i], read S[j], read the
//            output entry while writing S[i], then write S[j].
//     read : one table read.   no-op : no table access.
//     init : table clear, then the same read and write loop per table entry.
//   Config port: cfg_write/cfg_index/cfg_data write key_low (0), key_high (1) or
//   key_length (2); other indexes are ignored. Write only while idle.
//   Reset: table reads as identity (valid bits clear at once, no sweep), i = j = 0,
//   key registers take their reset key. Key length 0 acts as 1, above
//   MAX_KEY_BYTES it saturates.
module rc4_keystream_engine_top
    import rc4_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rc4_req_t              req,
    output logic                  busy,
    output logic                  done,
    output rc4_rsp_t              rsp,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    // Key bytes beyond MAX_KEY_BYTES are never used, so they are not stored.
    logic [MAX_KEY_BYTES-1:0][7:0] key_reg;
    logic [KEY_LEN_W-1:0]          key_len_reg;
    logic [KW-1:0]                 key_last;
    mem_req_t                      mem_req;
    logic [7:0]                    rd_data;

    for (genvar b = 0; b < MAX_KEY_BYTES; b++)
    begin : g_key
        localparam logic [CFG_IDX_W-1:0] WORD_SEL = (b < 8) ? CFG_KEY_LOW : CFG_KEY_HIGH;
        localparam int unsigned          LANE     = b % 8;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                key_reg[b] <= KEY_RESET[8*b +: 8];
            end
            else if (cfg_write && cfg_index == WORD_SEL)
            begin
                key_reg[b] <= cfg_data[8*LANE +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= KEY_LEN_RESET;
        end
        else if (cfg_write && cfg_index == CFG_KEY_LEN)
        begin
            key_len_reg <= cfg_data[KEY_LEN_W-1:0];
        end
    end

    // Last key position used by the schedule's cyclic key walk.
    always_comb
    begin
        priority if (key_len_reg == '0)
            key_last = '0;
        else if (key_len_reg > KEY_LEN_W'(MAX_KEY_BYTES))
            key_last = KW'(MAX_KEY_BYTES - 1);
        else
            key_last = KW'(key_len_reg - 1'b1);
    end

    rc4_seq #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .KW            (KW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .key_bytes (key_reg),
        .key_last  (key_last),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    rc4_sbox_mem u_sbox (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

### verif/tb_rc4_keystream_engine_top.sv
// Self-checking testbench for the RC4 keystream engine against a local RC4 predictor.
module tb_rc4_keystream_engine_top;
    import rc4_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned KEY_BYTES_MAX = 16;
    // Worst case is every word an init plus sender gaps; taken about 4x over.
    localparam int unsigned CYCLE_LIMIT   = 8_000_000;
    // Longest command latency (init), waited out once more at the end for stray results.
    localparam int unsigned SETTLE_CYCLES = 1030;
    localparam int unsigned RANDOM_TARGET = 1850;
    localparam int unsigned REPORT_MAX    = 10;
    // Index 3 of the config port decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    rc4_req_t              req_word;
    logic                  busy;
    logic                  done;
    rc4_rsp_t              rsp_word;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the engine: key registers, permutation and the two indices.
    logic [63:0]          key_lo_shadow;
    logic [63:0]          key_hi_shadow;
    logic [KEY_LEN_W-1:0] key_len_shadow;
    logic [7:0]           perm_shadow [256];
    logic [7:0]           pos_i;
    logic [7:0]           pos_j;

    // Result words still owed by the engine, oldest first.
    rc4_rsp_t    rsp_pending [$];

    bit          gaps_on = 1'b1;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned reported = 0;
    int unsigned results_checked = 0;
    int unsigned random_items = 0;
    int unsigned settings_used = 1;
    int unsigned op_count [4];

    rc4_keystream_engine_top #(
        .MAX_KEY_BYTES (KEY_BYTES_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req_word),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, rsp_pending.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor: applies one accepted word to the shadow state and
    // returns the result word the engine must produce for it.
    // ---------------------------------------------------------------
    function automatic rc4_rsp_t rc4_next_result(rc4_req_t w);
        rc4_rsp_t     r;
        logic [127:0] key_bits;
        int unsigned  klen;
        logic [7:0]   jj;
        logic [7:0]   tmp;
        logic [7:0]   sum;
        r = '0;
        case (w.req_type)
            REQ_INIT:
            begin
                // Key schedule: zero length acts as one byte, long keys saturate.
                key_bits = {key_hi_shadow, key_lo_shadow};
                klen = 32'(key_len_shadow);
                if (klen == 0)
                    klen = 1;
                if (klen > KEY_BYTES_MAX)
                    klen = KEY_BYTES_MAX;
                for (int n = 0; n < 256; n++)
                    perm_shadow[n] = n[7:0];
                jj = 8'd0;
                for (int n = 0; n < 256; n++)
                begin
                    jj = jj + perm_shadow[n] + key_bits[(n % klen) * 8 +: 8];
                    tmp = perm_shadow[n];
                    perm_shadow[n] = perm_shadow[jj];
                    perm_shadow[jj] = tmp;
                end
                pos_i = 8'd0;
                pos_j = 8'd0;
            end
            REQ_STEP:
            begin
                pos_i = pos_i + 8'd1;
                pos_j = pos_j + perm_shadow[pos_i];
                tmp = perm_shadow[pos_i];
                perm_shadow[pos_i] = perm_shadow[pos_j];
                perm_shadow[pos_j] = tmp;
                sum = perm_shadow[pos_i] + perm_shadow[pos_j];
                r.data_byte = perm_shadow[sum];
            end
            REQ_READ:
                r.data_byte = perm_shadow[w.entry_index];
            default:
                r.data_byte = 8'd0;
        endcase
        r.index_i = pos_i;
        r.index_j = pos_j;
        return r;
    endfunction

    function automatic rc4_req_t mk_word(req_code_t op, logic [7:0] idx);
        rc4_req_t w;
        w.req_type = op;
        w.entry_index = idx;
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Sender. Drives at the falling edge, then watches busy at each
    // rising edge; the word is taken at the first edge with busy low.
    // start stays high afterwards so back-to-back words need no drop.
    // ---------------------------------------------------------------
    task automatic issue_word(rc4_req_t w);
        @(negedge clk);
        if (gaps_on)
        begin
            while ($urandom_range(99) < 31)
            begin
                start = 1'b0;
                @(negedge clk);
            end
        end
        start = 1'b1;
        req_word = w;
        do
            @(posedge clk);
        while (busy);
        rsp_pending.push_back(rc4_next_result(w));
        op_count[w.req_type]++;
    endtask

    // Stop sending and wait for every owed result and an idle engine.
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (rsp_pending.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Register write; only called with the engine idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            CFG_KEY_LOW:  key_lo_shadow = data;
            CFG_KEY_HIGH: key_hi_shadow = data;
            CFG_KEY_LEN:  key_len_shadow = data[KEY_LEN_W-1:0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Checker: one result word per done strobe, sampled at the edge
    // that ends the strobe cycle, compared field by field.
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (reported < REPORT_MAX)
            begin
                reported++;
                $display("mismatch at cycle %0d, %s: expected %0d, got %0d",
                         cycle_count, name, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rc4_rsp_t want;
        if (rst_n && done)
        begin
            if (rsp_pending.size() == 0)
            begin
                fail_count++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("result word with nothing owed at cycle %0d: %0d/%0d/%0d",
                             cycle_count, rsp_word.data_byte, rsp_word.index_i,
                             rsp_word.index_j);
                end
            end
            else
            begin
                want = rsp_pending.pop_front();
                check_field("data_byte", want.data_byte, rsp_word.data_byte);
                check_field("index_i", want.index_i, rsp_word.index_i);
                check_field("index_j", want.index_j, rsp_word.index_j);
                results_checked++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Right after reset: identity table, i = j = 0, reset key in place.
    task automatic test_reset_state();
        issue_word(mk_word(REQ_READ, 8'h00));
        issue_word(mk_word(REQ_READ, 8'hFF));
        issue_word(mk_word(REQ_NOP, 8'hFF));
        // First step on the identity table swaps S[1] with itself.
        issue_word(mk_word(REQ_STEP, 8'h00));
        issue_word(mk_word(REQ_READ, 8'h01));
        issue_word(mk_word(REQ_STEP, 8'h55));
    endtask

    // Init with the reset key, then every request type in turn.
    task automatic test_each_request();
        issue_word(mk_word(REQ_INIT, 8'hAA));
        issue_word(mk_word(REQ_STEP, 8'h00));
        issue_word(mk_word(REQ_STEP, 8'hFF));
        issue_word(mk_word(REQ_READ, 8'h00));
        issue_word(mk_word(REQ_READ, 8'hFF));
        issue_word(mk_word(REQ_NOP, 8'h5A));
        issue_word(mk_word(REQ_READ, 8'h02));
    endtask

    // Key extremes and lengths at and past both ends of the legal range.
    task automatic test_key_length_edges();
        drain_results();
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LEN, 64'd16);
        issue_word(mk_word(REQ_INIT, 8'h00));
        issue_word(mk_word(REQ_STEP, 8'h00));

        drain_results();
        write_reg(CFG_KEY_LOW, '0);
        write_reg(CFG_KEY_HIGH, '0);
        write_reg(CFG_KEY_LEN, 64'd1);
        issue_word(mk_word(REQ_INIT, 8'h00));
        issue_word(mk_word(REQ_STEP, 8'h00));

        // Zero length behaves as a one-byte key.
        drain_results();
        write_reg(CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(CFG_KEY_LEN, 64'd0);
        issue_word(mk_word(REQ_INIT, 8'h00));
        issue_word(mk_word(REQ_READ, 8'h80));

        // Lengths above the maximum saturate; upper data bits are dropped.
        drain_results();
        write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(CFG_KEY_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        issue_word(mk_word(REQ_INIT, 8'h00));
        issue_word(mk_word(REQ_STEP, 8'h00));

        drain_results();
        write_reg(CFG_KEY_LEN, 64'd17);
        issue_word(mk_word(REQ_INIT, 8'h00));
        issue_word(mk_word(REQ_STEP, 8'h00));

        // Unmapped register index must leave the key alone.
        drain_results();
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        issue_word(mk_word(REQ_INIT, 8'h00));
        settings_used += 5;
    endtask

    // One long keystream run without sender gaps so i and j wrap past 255.
    task automatic test_index_wrap();
        logic [63:0] d;
        drain_results();
        d = {$urandom, $urandom};
        d[KEY_LEN_W-1:0] = 5'd16;
        write_reg(CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(CFG_KEY_LEN, d);
        settings_used++;
        gaps_on = 1'b0;
        issue_word(mk_word(REQ_INIT, 8'($urandom_range(255))));
        random_items++;
        for (int k = 0; k < 640; k++)
        begin
            if ($urandom_range(99) < 85)
                issue_word(mk_word(REQ_STEP, 8'($urandom_range(255))));
            else
                issue_word(mk_word(REQ_READ, 8'($urandom_range(255))));
            random_items++;
        end
        gaps_on = 1'b1;
    endtask

    // Phases: new random key setting, init, then a random word mix.
    // A few phases skip the init and keep running on the old state.
    task automatic test_random_phases();
        int unsigned          n_items;
        int unsigned          pick;
        logic [KEY_LEN_W-1:0] klen;
        logic [63:0]          d;
        req_code_t            op;
        while (random_items < RANDOM_TARGET)
        begin
            drain_results();
            if ($urandom_range(7) == 0)
                klen = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
            else
                klen = 5'($urandom_range(1, 16));
            d = {$urandom, $urandom};
            d[KEY_LEN_W-1:0] = klen;
            write_reg(CFG_KEY_LOW, {$urandom, $urandom});
            write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
            write_reg(CFG_KEY_LEN, d);
            settings_used++;
            if ($urandom_range(19) != 0)
            begin
                issue_word(mk_word(REQ_INIT, 8'($urandom_range(255))));
                random_items++;
            end
            n_items = $urandom_range(10, 150);
            for (int k = 0; k < n_items; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    op = REQ_STEP;
                else if (pick < 88)
                    op = REQ_READ;
                else if (pick < 96)
                    op = REQ_NOP;
                else
                    op = REQ_INIT;
                issue_word(mk_word(op, 8'($urandom_range(255))));
                random_items++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_word = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_KEY_LOW;
        cfg_data = '0;
        key_lo_shadow = KEY_RESET[63:0];
        key_hi_shadow = KEY_RESET[127:64];
        key_len_shadow = KEY_LEN_RESET;
        for (int n = 0; n < 256; n++)
            perm_shadow[n] = n[7:0];
        pos_i = 8'd0;
        pos_j = 8'd0;
        for (int n = 0; n < 4; n++)
            op_count[n] = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_each_request();
        test_key_length_edges();
        test_index_wrap();
        test_random_phases();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d inits, %0d steps, %0d reads, %0d no-ops over %0d key settings.",
                 op_count[REQ_INIT], op_count[REQ_STEP], op_count[REQ_READ],
                 op_count[REQ_NOP], settings_used);
        $display("Checked %0d result words in %0d cycles; %0d field errors.",
                 results_checked, cycle_count, fail_count);
        if (fail_count == 0 && rsp_pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
